// File: hw/rtl/ust_pkg.sv
// shared types and constants for the user slot table
package ust_pkg;

  localparam logic [2:0] CMD_FIND_CARD   = 3'd0;
  localparam logic [2:0] CMD_FIND_FINGER = 3'd1;
  localparam logic [2:0] CMD_FIND_ID     = 3'd2;
  localparam logic [2:0] CMD_UPDATE      = 3'd3;
  localparam logic [2:0] CMD_CREATE      = 3'd4;
  localparam logic [2:0] CMD_DELETE      = 3'd5;

  localparam logic [15:0] ID_LIMIT  = 16'hFFF0;
  localparam logic [6:0]  COUNT_MAX = 7'd127;

  typedef struct packed {
    logic        valid;
    logic [15:0] id;
    logic [31:0] card;
    logic [15:0] finger;
  } ent_t;

endpackage

// File: hw/rtl/ust_table.sv
// slot table memory, one write port and one registered read port
module ust_table #(
  parameter int SLOTS = 64,
  parameter int IW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  ust_pkg::ent_t wdata,
  input  logic [IW-1:0] raddr,
  output ust_pkg::ent_t rdata
);
  import ust_pkg::*;

  ent_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ust_seen.sv
// bitmap of ids in use, for the smallest free id search
module ust_seen #(
  parameter int DEPTH = 66,
  parameter int SW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [SW-1:0] waddr,
  input  logic          wbit,
  input  logic [SW-1:0] raddr,
  output logic          rbit
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wbit;
    end
    rbit <= mem[raddr];
  end

endmodule

// File: hw/rtl/user_slot_table_core.sv
// user slot table: command sequencer over the slot memory and the id bitmap
//
// Input channel: in_valid/in_stall carry one command (find by card, finger or
// id, update, create, delete) with card_uid, finger_key and user_id. Output
// channel: out_valid/out_stall carry one result per command: ok, slot,
// found_id, found_card, found_finger, count and next_free.
// Each valid command walks the slot memory one slot at a time through its
// single read port, reading a slot and then checking it. A delete adds a
// downward walk for the highest valid slot and one free id search; a create
// does two free id searches. A free id search clears the id bitmap, marks it
// from the table and walks it for the smallest free id.
// in_stall is high while a command is in progress; one command at a time.
// The result sits in an output register; the next command is taken while it
// waits, and a finished result waits in the sequencer while out_stall is high.
// After reset the table is cleared one slot per cycle, with in_stall high;
// the count starts at zero and the next free id at one.
module user_slot_table_core #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [31:0] card_uid,
  input  logic [15:0] finger_key,
  input  logic [15:0] user_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [5:0]  slot,
  output logic [15:0] found_id,
  output logic [31:0] found_card,
  output logic [15:0] found_finger,
  output logic [6:0]  count,
  output logic [15:0] next_free
);
  import ust_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int SDEPTH = SLOTS + 2;
  localparam int SW = $clog2(SDEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
  localparam logic [SW-1:0] SEEN_TOP = SW'(SLOTS + 1);
  localparam logic [15:0] ID_TOP = 16'(SLOTS + 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_CK, S_LRD, S_LCK, S_MOVE, S_KILL,
    S_FCLR, S_FRD, S_FCK, S_SRD, S_SCK, S_CRE, S_OUT
  } state_t;

  typedef enum logic [1:0] {P_NEW, P_AFTER, P_DEL} pass_t;

  state_t state;
  pass_t pass;
  logic [2:0] cmd;
  logic [31:0] card;
  logic [15:0] finger;
  logic [15:0] uid;
  logic [IW-1:0] idx;
  logic [IW-1:0] hit;
  ent_t ldata;
  logic [SW-1:0] sidx;
  logic [15:0] nid;
  logic [6:0] users;
  logic [15:0] lowest;
  logic r_ok;
  logic [IW-1:0] r_slot;
  logic [15:0] r_id;
  logic [31:0] r_card;
  logic [15:0] r_finger;

  logic tw_en;
  logic [IW-1:0] tw_addr;
  ent_t tw_data;
  ent_t rdata;
  logic sw_en;
  logic [SW-1:0] sw_addr;
  logic sw_bit;
  logic sbit;
  logic match;
  logic id_free;
  logic [15:0] sval;

  ust_table #(.SLOTS(SLOTS), .IW(IW)) u_table (
    .clk(clk), .we(tw_en), .waddr(tw_addr), .wdata(tw_data),
    .raddr(idx), .rdata(rdata)
  );

  ust_seen #(.DEPTH(SDEPTH), .SW(SW)) u_seen (
    .clk(clk), .we(sw_en), .waddr(sw_addr), .wbit(sw_bit),
    .raddr(sidx), .rbit(sbit)
  );

  assign in_stall = (state != S_IDLE);

  always_comb begin
    case (cmd)
      CMD_FIND_CARD:   match = rdata.valid && (rdata.card == card);
      CMD_FIND_FINGER: match = rdata.valid && (rdata.finger == finger);
      CMD_CREATE:      match = !rdata.valid;
      default:         match = rdata.valid && (uid != 16'd0) && (rdata.id == uid);
    endcase
  end

  assign id_free = !sbit && (16'(sidx) < ID_LIMIT);
  assign sval = id_free ? 16'(sidx) : 16'd0;

  // table write port
  always_comb begin
    tw_en = 1'b0;
    tw_addr = idx;
    tw_data = '0;
    unique case (state)
      S_CLR: tw_en = 1'b1;
      S_CK: begin
        if (match && cmd == CMD_UPDATE) begin
          tw_en = 1'b1;
          tw_data = '{valid: 1'b1, id: rdata.id, card: card, finger: finger};
        end
      end
      S_MOVE: begin
        tw_en = 1'b1;
        tw_addr = hit;
        tw_data = ldata;
      end
      S_KILL: tw_en = 1'b1;
      S_CRE: begin
        tw_en = 1'b1;
        tw_addr = hit;
        tw_data = '{valid: 1'b1, id: nid, card: card, finger: finger};
      end
      default: tw_en = 1'b0;
    endcase
  end

  // bitmap write port
  always_comb begin
    sw_en = 1'b0;
    sw_addr = sidx;
    sw_bit = 1'b0;
    unique case (state)
      S_FCLR: sw_en = 1'b1;
      S_FCK: begin
        sw_en = rdata.valid && (rdata.id <= ID_TOP);
        sw_addr = rdata.id[SW-1:0];
        sw_bit = 1'b1;
      end
      default: sw_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      pass <= P_NEW;
      idx <= '0;
      sidx <= '0;
      users <= '0;
      lowest <= 16'd1;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          if (idx == LAST_SLOT) begin
            idx <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd <= command;
            card <= card_uid;
            finger <= finger_key;
            uid <= user_id;
            idx <= '0;
            r_ok <= 1'b0;
            r_slot <= '0;
            r_id <= '0;
            r_card <= '0;
            r_finger <= '0;
            state <= (command <= CMD_DELETE) ? S_RD : S_OUT;
          end
        end
        S_RD: state <= S_CK;
        S_CK: begin
          if (match) begin
            hit <= idx;
            if (cmd == CMD_DELETE) begin
              r_ok <= 1'b1;
              r_slot <= idx;
              r_id <= rdata.id;
              r_card <= rdata.card;
              r_finger <= rdata.finger;
              idx <= LAST_SLOT;
              state <= S_LRD;
            end else if (cmd == CMD_CREATE) begin
              pass <= P_NEW;
              sidx <= '0;
              state <= S_FCLR;
            end else begin
              r_ok <= 1'b1;
              r_slot <= idx;
              r_id <= rdata.id;
              r_card <= (cmd == CMD_UPDATE) ? card : rdata.card;
              r_finger <= (cmd == CMD_UPDATE) ? finger : rdata.finger;
              state <= S_OUT;
            end
          end else if (idx == LAST_SLOT) begin
            state <= S_OUT;
          end else begin
            idx <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_LRD: state <= S_LCK;
        S_LCK: begin
          if (rdata.valid || idx == '0) begin
            ldata <= rdata;
            state <= S_MOVE;
          end else begin
            idx <= idx - 1'b1;
            state <= S_LRD;
          end
        end
        S_MOVE: state <= S_KILL;
        S_KILL: begin
          if (users != '0) begin
            users <= users - 1'b1;
          end
          pass <= P_DEL;
          sidx <= '0;
          state <= S_FCLR;
        end
        S_FCLR: begin
          if (sidx == SEEN_TOP) begin
            idx <= '0;
            state <= S_FRD;
          end else begin
            sidx <= sidx + 1'b1;
          end
        end
        S_FRD: state <= S_FCK;
        S_FCK: begin
          if (idx == LAST_SLOT) begin
            sidx <= SW'(1);
            state <= S_SRD;
          end else begin
            idx <= idx + 1'b1;
            state <= S_FRD;
          end
        end
        S_SRD: state <= S_SCK;
        S_SCK: begin
          if (id_free || sidx == SEEN_TOP) begin
            unique case (pass)
              P_NEW: begin
                if (sval == 16'd0) begin
                  state <= S_OUT;
                end else begin
                  nid <= sval;
                  state <= S_CRE;
                end
              end
              P_AFTER: begin
                lowest <= sval;
                r_ok <= 1'b1;
                r_slot <= hit;
                r_id <= nid;
                r_card <= card;
                r_finger <= finger;
                state <= S_OUT;
              end
              default: begin
                lowest <= sval;
                state <= S_OUT;
              end
            endcase
          end else begin
            sidx <= sidx + 1'b1;
            state <= S_SRD;
          end
        end
        S_CRE: begin
          if (users != COUNT_MAX) begin
            users <= users + 1'b1;
          end
          pass <= P_AFTER;
          sidx <= '0;
          state <= S_FCLR;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            ok <= r_ok;
            slot <= 6'(r_slot);
            found_id <= r_id;
            found_card <= r_card;
            found_finger <= r_finger;
            count <= users;
            next_free <= lowest;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a command is taken only from idle, and the sequencer leaves idle at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("command accepted but sequencer stayed idle");

  // a result is only launched from the result state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result launched outside the result state");

  // a create below saturation adds exactly one user
  a_create_count: assert property (@(posedge clk) disable iff (rst)
    state == S_CRE && users != COUNT_MAX |=> users == $past(users) + 7'd1)
    else $error("user count not advanced on create");

  // with at most SLOTS ids in use some id up to SLOTS+1 is always free
  a_free_nonzero: assert property (@(posedge clk) disable iff (rst)
    lowest != 16'd0)
    else $error("next free id lost");

endmodule
